// ===== hdl/vssp_pkg.sv =====
// Shared types and constants of the variable speed sample player.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package vssp_pkg;

  // Default sizes. STORE_DEPTH must be a power of two.
  localparam int unsigned STORE_DEPTH_DEF = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned FRAC_W    = 16;  // phase fraction
  localparam int unsigned IDX_W     = 16;  // frame index
  localparam int unsigned LEN_W     = 17;  // clip length in frames
  localparam int unsigned SPEED_W   = 18;  // Q2.16 speed
  localparam int unsigned PHASE_W   = 32;  // 16.16 phase
  localparam int unsigned PHX_W     = PHASE_W + 1;
  localparam int unsigned OUT_W     = 16;  // result sample width
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  // Result queue
  localparam int unsigned OFIFO_DEPTH = 8;
  localparam int unsigned OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int unsigned OUTST_W     = $clog2(OFIFO_DEPTH + 1);

  localparam logic [LEN_W-1:0]   MAX_LEN  = 17'h10000;
  localparam logic [LEN_W-1:0]   ONE_Q16  = 17'h10000;
  localparam logic [FRAC_W-1:0]  TRUNC_BIAS = 16'hFFFF;

  // Register reset values
  localparam logic [SPEED_W-1:0] SPEED_RST  = 18'h10000;
  localparam logic               LOOP_RST   = 1'b0;
  localparam logic [LEN_W-1:0]   LENGTH_RST = 17'd1;
  localparam logic               STEREO_RST = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd3;

  // Item kinds
  localparam logic [IN_USER_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [IN_USER_W-1:0] KIND_RESTART = 2'd1;
  localparam logic [IN_USER_W-1:0] KIND_FRAME   = 2'd2;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_KDIV,
    CS_READ
  } ctrl_state_e;

  // Travels with each store read down the datapath
  typedef struct packed {
    logic              valid;
    logic              is_b;    // right neighbour of the pair
    logic              chan;
    logic              last;    // final read of the frame
    logic              zero_b;  // neighbour past clip end reads as silence
    logic              silent;  // frame past end, no read
    logic              done;
    logic [FRAC_W-1:0] frac;
  } rd_tag_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] right;
    logic [OUT_W-1:0] left;
  } result_t;

endpackage

// ===== hdl/vssp_rem.sv =====
// Serial remainder unit: frame index modulo clip length, one bit per cycle.
// Depends on vssp_pkg.
`timescale 1ns / 1ps

module vssp_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [vssp_pkg::IDX_W-1:0] dividend_i,
  input  logic [vssp_pkg::LEN_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [vssp_pkg::IDX_W-1:0] rem_o
);
  import vssp_pkg::*;

  localparam int unsigned CNT_W = $clog2(IDX_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [LEN_W-1:0] rem_q;
  logic [IDX_W-1:0] dvd_q;
  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   trial_sub;
  logic [LEN_W-1:0] rem_next;

  always_comb begin
    trial     = {rem_q, dvd_q[IDX_W-1]};
    trial_sub = trial - {1'b0, divisor_i};
    if (trial >= {1'b0, divisor_i}) begin
      rem_next = trial_sub[LEN_W-1:0];
    end else begin
      rem_next = trial[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(IDX_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[IDX_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IDX_W-1:0];

endmodule

// ===== hdl/vssp_store.sv =====
// Sample store: one write port, one registered read port, read-first.
// The read tag is delayed with the data. Depends on vssp_pkg.
`timescale 1ns / 1ps

module vssp_store #(
  parameter  int unsigned STORE_DEPTH = vssp_pkg::STORE_DEPTH_DEF,
  parameter  int unsigned SAMPLE_BITS = vssp_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned AW          = $clog2(STORE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic [SAMPLE_BITS-1:0] wr_data_i,
  input  logic [AW-1:0]          rd_addr_i,
  input  vssp_pkg::rd_tag_t      rd_tag_i,
  output logic [SAMPLE_BITS-1:0] rd_data_o,
  output vssp_pkg::rd_tag_t      rd_tag_o
);
  import vssp_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  rd_tag_t                rd_tag_q;

  // a read in the same cycle as a write to that entry sees the old value
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_tag_q <= '0;
    end else begin
      rd_tag_q <= rd_tag_i;
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_tag_o  = rd_tag_q;

endmodule

// ===== hdl/vssp_interp.sv =====
// Interpolation datapath (weight multiply, pair sum, truncation) and the
// result queue that feeds the output stream. Depends on vssp_pkg.
`timescale 1ns / 1ps

module vssp_interp #(
  parameter int unsigned SAMPLE_BITS = vssp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [SAMPLE_BITS-1:0]             rd_data_i,
  input  vssp_pkg::rd_tag_t                  rd_tag_i,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [vssp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // left_sample, right_sample
  output logic [vssp_pkg::OUT_USER_W-1:0]    m_axis_tuser   // done_res
);
  import vssp_pkg::*;

  localparam int unsigned PW = SAMPLE_BITS + 18;  // product
  localparam int unsigned SW = PW + 1;            // pair sum

  rd_tag_t               tag2_q;
  rd_tag_t               tag3_q;
  logic [FRAC_W:0]       coef;
  logic signed [PW-1:0]  samp_x;
  logic signed [PW-1:0]  coef_x;
  logic signed [PW-1:0]  prod_q;
  logic signed [PW-1:0]  pa_q;
  logic signed [SW-1:0]  sum_q;
  logic signed [SW-1:0]  biased;
  logic signed [SW-1:0]  shifted;
  logic [OUT_W-1:0]      res;
  logic [OUT_W-1:0]      left_q;
  logic                  push;
  result_t               push_data;

  result_t               fifo_q [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0]   wptr_q;
  logic [OFIFO_AW-1:0]   rptr_q;
  logic [OUTST_W-1:0]    cnt_q;
  logic                  pop;

  // weights: (1 - f) for the current frame, f for the next one
  always_comb begin
    if (rd_tag_i.is_b) begin
      coef = {1'b0, rd_tag_i.frac};
    end else begin
      coef = ONE_Q16 - {1'b0, rd_tag_i.frac};
    end
    coef_x = PW'(coef);
    if (rd_tag_i.is_b && rd_tag_i.zero_b) begin
      samp_x = '0;
    end else begin
      samp_x = PW'($signed(rd_data_i));
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= samp_x * coef_x;
    if (tag2_q.valid && !tag2_q.is_b && !tag2_q.silent) begin
      pa_q <= prod_q;
    end
    sum_q <= SW'(pa_q) + SW'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag2_q       <= rd_tag_i;
      tag3_q       <= tag2_q;
      tag3_q.valid <= tag2_q.valid && (tag2_q.is_b || tag2_q.silent);
    end
  end

  // divide by 65536 truncating toward zero
  always_comb begin
    if (sum_q[SW-1]) begin
      biased = sum_q + SW'(TRUNC_BIAS);
    end else begin
      biased = sum_q;
    end
    shifted = biased >>> FRAC_W;
    res     = shifted[OUT_W-1:0];
  end

  always_comb begin
    push = tag3_q.valid && (tag3_q.silent || tag3_q.last);
    if (tag3_q.silent) begin
      push_data.done  = 1'b1;
      push_data.left  = '0;
      push_data.right = '0;
    end else begin
      push_data.done  = tag3_q.done;
      push_data.left  = tag3_q.chan ? left_q : res;
      push_data.right = tag3_q.chan ? res : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag3_q.valid && !tag3_q.last && !tag3_q.silent) begin
      left_q <= res;
    end
    if (push) begin
      fifo_q[wptr_q] <= push_data;
    end
  end

  // room is guaranteed by the issue credit count
  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + OFIFO_AW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + OFIFO_AW'(1);
      end
      cnt_q <= cnt_q + OUTST_W'(push) - OUTST_W'(pop);
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {fifo_q[rptr_q].right, fifo_q[rptr_q].left};
  assign m_axis_tuser  = fifo_q[rptr_q].done;

endmodule

// ===== hdl/vssp_ctrl.sv =====
// Control: registers, phase accumulator, input handshake and the read
// sequencer driving the sample store. Depends on vssp_pkg and vssp_rem.
`timescale 1ns / 1ps

module vssp_ctrl #(
  parameter  int unsigned STORE_DEPTH = vssp_pkg::STORE_DEPTH_DEF,
  parameter  int unsigned SAMPLE_BITS = vssp_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned AW          = $clog2(STORE_DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [vssp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [vssp_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vssp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vssp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            res_pop_i,
  output logic                            wr_en_o,
  output logic [AW-1:0]                   wr_addr_o,
  output logic [SAMPLE_BITS-1:0]          wr_data_o,
  output logic [AW-1:0]                   rd_addr_o,
  output vssp_pkg::rd_tag_t               rd_tag_o
);
  import vssp_pkg::*;

  function automatic logic [PHASE_W-1:0] wrap_phase(
    input logic [IDX_W-1:0]   r,
    input logic [FRAC_W-1:0]  fr,
    input logic [SPEED_W-1:0] spd,
    input logic [LEN_W-1:0]   n
  );
    logic [PHX_W-1:0] p;
    logic [LEN_W-1:0] hi;
    logic [LEN_W-1:0] hi1;
    logic [LEN_W-1:0] hi2;
    logic [LEN_W-1:0] hw;
    // r < n and speed < 4, so for n >= 2 the sum passes the end by less than two clip lengths
    p   = {1'b0, r, fr} + PHX_W'(spd);
    hi  = p[PHASE_W:FRAC_W];
    hi1 = hi - n;
    hi2 = hi1 - n;
    if (hi < n) begin
      hw = hi;
    end else if (hi1 < n) begin
      hw = hi1;
    end else begin
      hw = hi2;
    end
    return {hw[IDX_W-1:0], p[FRAC_W-1:0]};
  endfunction

  ctrl_state_e          state_q, state_d;
  logic [SPEED_W-1:0]   speed_q;
  logic                 loop_q;
  logic [LEN_W-1:0]     length_q;
  logic                 stereo_q;
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [1:0]           slot_q, slot_d;
  logic [IDX_W-1:0]     r_q, r_d;
  logic [FRAC_W-1:0]    frac_q, frac_d;
  logic                 zero_b_q, zero_b_d;
  logic                 silent_q, silent_d;
  logic                 done_q, done_d;
  logic [OUTST_W-1:0]   outst_q, outst_d;

  logic [LEN_W-1:0]     len;
  logic                 in_fire;
  logic                 frame_fire;
  logic                 credit_ok;
  logic                 last_slot;
  logic [1:0]           last_idx;
  logic [IDX_W-1:0]     k;
  logic [FRAC_W-1:0]    f;
  logic [PHX_W-1:0]     end_ph;
  logic [PHX_W-1:0]     adv_sum;
  logic [PHX_W-1:0]     adv_sat;
  logic                 rem_start;
  logic                 rem_done;
  logic [IDX_W-1:0]     rem_val;
  logic [LEN_W-1:0]     r_inc;
  logic [IDX_W-1:0]     fi;
  logic [LEN_W-1:0]     idx;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= SPEED_RST;
      loop_q   <= LOOP_RST;
      length_q <= LENGTH_RST;
      stereo_q <= STEREO_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SPEED:  speed_q  <= cfg_data_i[SPEED_W-1:0];
        CFG_LOOP:   loop_q   <= cfg_data_i[0];
        CFG_LENGTH: length_q <= cfg_data_i[LEN_W-1:0];
        CFG_STEREO: stereo_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (length_q == '0) begin
      len = LEN_W'(1);
    end else if (length_q > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = length_q;
    end
  end

  // ---------------- handshake ----------------
  assign last_idx   = silent_q ? 2'd0 : (stereo_q ? 2'd3 : 2'd1);
  assign last_slot  = (state_q == CS_READ) && (slot_q == last_idx);
  assign credit_ok  = (outst_q < OUTST_W'(OFIFO_DEPTH));
  assign s_axis_tready = credit_ok && ((state_q == CS_IDLE) || last_slot);
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign frame_fire = in_fire && (s_axis_tuser == KIND_FRAME);

  assign wr_en_o   = in_fire && (s_axis_tuser == KIND_WRITE);
  assign wr_addr_o = AW'(s_axis_tdata[IDX_W-1:0]);
  assign wr_data_o = SAMPLE_BITS'($signed(s_axis_tdata[IN_DATA_W-1:IDX_W]));

  // ---------------- phase and sequencing ----------------
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    slot_d    = slot_q;
    r_d       = r_q;
    frac_d    = frac_q;
    zero_b_d  = zero_b_q;
    silent_d  = silent_q;
    done_d    = done_q;
    rem_start = 1'b0;

    k       = phase_q[PHASE_W-1:FRAC_W];
    f       = phase_q[FRAC_W-1:0];
    end_ph  = {len, {FRAC_W{1'b0}}};
    adv_sum = {1'b0, phase_q} + PHX_W'(speed_q);
    adv_sat = adv_sum[PHASE_W] ? {1'b0, {PHASE_W{1'b1}}} : adv_sum;

    case (state_q)
      CS_KDIV: begin
        if (rem_done) begin
          r_d     = rem_val;
          phase_d = wrap_phase(rem_val, frac_q, speed_q, len);
          slot_d  = '0;
          state_d = CS_READ;
        end
      end
      CS_READ: begin
        if (last_slot) begin
          state_d = CS_IDLE;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
      default: ;
    endcase

    if (in_fire) begin
      case (s_axis_tuser)
        KIND_RESTART: phase_d = '0;
        KIND_FRAME: begin
          slot_d   = '0;
          r_d      = k;
          frac_d   = f;
          zero_b_d = 1'b0;
          silent_d = 1'b0;
          done_d   = 1'b0;
          state_d  = CS_READ;
          if (!loop_q) begin
            if ({1'b0, phase_q} >= end_ph) begin
              // past the end: silence, phase holds
              silent_d = 1'b1;
              done_d   = 1'b1;
            end else begin
              zero_b_d = (({1'b0, k} + LEN_W'(1)) >= len);
              phase_d  = adv_sat[PHASE_W-1:0];
              done_d   = (adv_sat >= end_ph);
            end
          end else if ({1'b0, k} < len) begin
            phase_d = wrap_phase(k, f, speed_q, len);
          end else begin
            // phase left beyond the clip (length changed): reduce k first
            rem_start = 1'b1;
            state_d   = CS_KDIV;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    outst_d = outst_q + OUTST_W'(frame_fire) - OUTST_W'(res_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= CS_IDLE;
      phase_q  <= '0;
      slot_q   <= '0;
      zero_b_q <= 1'b0;
      silent_q <= 1'b0;
      done_q   <= 1'b0;
      outst_q  <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      slot_q   <= slot_d;
      zero_b_q <= zero_b_d;
      silent_q <= silent_d;
      done_q   <= done_d;
      outst_q  <= outst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    frac_q <= frac_d;
  end

  vssp_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (k),
    .divisor_i  (len),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // ---------------- read address ----------------
  // slot order: a0, b0, a1, b1 (a = frame k, b = frame k+1, wrapped)
  always_comb begin
    r_inc = {1'b0, r_q} + LEN_W'(1);
    if (!slot_q[0]) begin
      fi = r_q;
    end else if (r_inc == len) begin
      fi = '0;
    end else begin
      fi = r_inc[IDX_W-1:0];
    end
    if (stereo_q) begin
      idx = {fi, slot_q[1]};
    end else begin
      idx = {1'b0, fi};
    end
    rd_addr_o = AW'(idx);

    rd_tag_o.valid  = (state_q == CS_READ);
    rd_tag_o.is_b   = slot_q[0];
    rd_tag_o.chan   = slot_q[1];
    rd_tag_o.last   = last_slot;
    rd_tag_o.zero_b = zero_b_q;
    rd_tag_o.silent = silent_q;
    rd_tag_o.done   = done_q;
    rd_tag_o.frac   = frac_q;
  end

endmodule

// ===== hdl/variable_speed_sample_player.sv =====
// Throughput: a frame past the clip end, a sample write or a restart per cycle
// while the result queue has credit and no remainder runs; a stereo or mono
// frame holds the input until its last read on the single store read port
// (one read per neighbour and channel). Looping from a phase beyond the clip
// first runs the serial remainder. Reset clears phase, control and registers
// to defaults; store contents stay undefined until written.
`timescale 1ns / 1ps

module variable_speed_sample_player #(
  parameter  int unsigned STORE_DEPTH = vssp_pkg::STORE_DEPTH_DEF,
  parameter  int unsigned SAMPLE_BITS = vssp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [vssp_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // write_address, write_value
  input  logic [vssp_pkg::IN_USER_W-1:0]  s_axis_tuser,   // kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [vssp_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // left_sample, right_sample
  output logic [vssp_pkg::OUT_USER_W-1:0] m_axis_tuser,   // done_res
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vssp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vssp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import vssp_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic [AW-1:0]          rd_addr;
  rd_tag_t                rd_tag;
  rd_tag_t                rd_tag_dly;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   res_pop;

  assign res_pop = m_axis_tvalid && m_axis_tready;

  vssp_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .res_pop_i     (res_pop),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_addr_o     (rd_addr),
    .rd_tag_o      (rd_tag)
  );

  vssp_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_tag_i  (rd_tag),
    .rd_data_o (rd_data),
    .rd_tag_o  (rd_tag_dly)
  );

  vssp_interp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_interp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_data_i     (rd_data),
    .rd_tag_i      (rd_tag_dly),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== test/vssp_frame_checker.sv =====
// Frame checker for the variable speed sample player: watches the item, result
// and register channels, predicts every frame and compares it with the block.
// Depends on vssp_pkg for widths, register indexes, item kinds and result_t.
`timescale 1ns / 1ps

module vssp_frame_checker
  import vssp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,   // write_address, write_value
  input  logic [IN_USER_W-1:0]  in_user_i,   // kind
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [OUT_DATA_W-1:0] out_data_i,  // left_sample, right_sample
  input  logic [OUT_USER_W-1:0] out_user_i,  // done_res
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o
);

  logic signed [OUT_W-1:0] clip_mem [0:STORE_DEPTH_DEF-1];
  logic [PHASE_W-1:0]      play_phase;
  logic [SPEED_W-1:0]      speed;
  logic                    loop_en;
  logic [LEN_W-1:0]        len_reg;
  logic                    stereo_en;

  result_t     frames_due [$];
  result_t     oldest;
  result_t     fresh;
  logic [15:0] got_left;
  logic [15:0] got_right;
  logic        got_done;
  int unsigned errs = 0;

  // Interpolates one frame at the current phase, then moves the phase on unless past the clip end.
  task automatic predict_frame(output result_t r);
    longint len, chans, total, span, k, f, a, b, acc, idx, nphase;
    r = '0;
    len = (len_reg == 0) ? 1 : (len_reg > MAX_LEN) ? longint'(MAX_LEN) : longint'(len_reg);
    chans = stereo_en ? 2 : 1;
    total = len * chans;
    span = len << FRAC_W;
    if (!loop_en && longint'(play_phase) >= span) begin
      // past the clip end: silence, phase holds
      r.done = 1'b1;
    end else begin
      k = longint'(play_phase[PHASE_W-1:FRAC_W]);
      f = longint'(play_phase[FRAC_W-1:0]);
      for (int c = 0; c < chans; c++) begin
        idx = ((k * chans + c) % total) % STORE_DEPTH_DEF;
        a = clip_mem[idx];
        if (!loop_en && k + 1 >= len) begin
          b = 0;
        end else begin
          idx = (((k + 1) * chans + c) % total) % STORE_DEPTH_DEF;
          b = clip_mem[idx];
        end
        acc = (a * (65536 - f) + b * f) / 65536;
        if (c == 0) r.left = acc[15:0];
        else r.right = acc[15:0];
      end
      nphase = longint'(play_phase) + longint'(speed);
      if (loop_en) begin
        nphase = nphase % span;
        r.done = 1'b0;
      end else begin
        if (nphase > 64'hFFFF_FFFF) nphase = 64'hFFFF_FFFF;
        r.done = (nphase >= span);
      end
      play_phase = nphase[PHASE_W-1:0];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_phase = '0;
      speed      = SPEED_RST;
      loop_en    = LOOP_RST;
      len_reg    = LENGTH_RST;
      stereo_en  = STEREO_RST;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SPEED:  speed     = cfg_data_i[SPEED_W-1:0];
          CFG_LOOP:   loop_en   = cfg_data_i[0];
          CFG_LENGTH: len_reg   = cfg_data_i[LEN_W-1:0];
          CFG_STEREO: stereo_en = cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        got_left  = out_data_i[15:0];
        got_right = out_data_i[31:16];
        got_done  = out_user_i[0];
        if (frames_due.size() == 0) begin
          $error("unexpected result: left %0d right %0d done %0b",
                 $signed(got_left), $signed(got_right), got_done);
          errs++;
        end else begin
          oldest = frames_due.pop_front();
          if (got_left !== oldest.left) begin
            $error("left_sample: expected %0d, got %0d",
                   $signed(oldest.left), $signed(got_left));
            errs++;
          end
          if (got_right !== oldest.right) begin
            $error("right_sample: expected %0d, got %0d",
                   $signed(oldest.right), $signed(got_right));
            errs++;
          end
          if (got_done !== oldest.done) begin
            $error("done_res: expected %0b, got %0b", oldest.done, got_done);
            errs++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        case (in_user_i)
          KIND_WRITE:   clip_mem[in_data_i[15:0]] = in_data_i[31:16];
          KIND_RESTART: play_phase = '0;
          KIND_FRAME: begin
            predict_frame(fresh);
            frames_due.push_back(fresh);
          end
          default: ;  // unused kind, dropped by the block
        endcase
      end

      pending_o <= frames_due.size();
    end
  end

  assign errors_o = errs;

endmodule

// ===== test/tb_top.sv =====
// Top of the sample player bench: clock, reset, item and register stimulus,
// result back-pressure and the verdict. Needs vssp_pkg, the player RTL and
// vssp_frame_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_top;
  import vssp_pkg::*;

  localparam logic [IN_USER_W-1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned CLIP_PREFIX    = 256;  // store entries always written
  localparam int unsigned MAX_REQS       = (CLIP_PREFIX - 4) / 8;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS    = 108;
  localparam int unsigned CHOKE_PHASE    = 3;
  localparam int unsigned CHOKE_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // write_address, write_value
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // left_sample, right_sample
  logic [OUT_USER_W-1:0] m_axis_tuser;        // done_res
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;
  bit          choke_req = 1'b0;
  bit          choke_done = 1'b0;

  always #5 clk_i = ~clk_i;

  variable_speed_sample_player dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  vssp_frame_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .errors_o    (mismatches)
  );

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic offer_item(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [15:0] value);
    int unsigned gap;
    gap = pick_gap(calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {value, addr};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Idle the input, let every frame come back, then give trailing work time.
  task automatic drain_player();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Upper bits of the one-bit registers carry noise; the block keeps bit 0.
  task automatic program_player(input logic [17:0] spd, input logic lp,
                                input logic [17:0] lenw, input logic st);
    logic [CFG_IDX_W-1:0]  order [4] = '{CFG_SPEED, CFG_LOOP, CFG_LENGTH, CFG_STEREO};
    logic [CFG_DATA_W-1:0] word  [4];
    word[0] = spd;
    word[1] = {17'($urandom), lp};
    word[2] = lenw;
    word[3] = {17'($urandom), st};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[i];
      cfg_data_i  <= word[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // First frames hold the full-scale extremes, the rest is random.
  task automatic load_clip();
    logic [15:0] value;
    for (int unsigned i = 0; i < CLIP_PREFIX; i++) begin
      case (i)
        0, 3:    value = 16'h8000;
        1, 2:    value = 16'h7FFF;
        default: value = $urandom;
      endcase
      offer_item(KIND_WRITE, i[15:0], value);
    end
  endtask

  task automatic directed_checks();
    // reset settings: one stereo frame, no loop, so end of clip at once
    offer_item(KIND_FRAME, $urandom, $urandom);
    offer_item(KIND_FRAME, $urandom, $urandom);
    offer_item(KIND_UNUSED, 16'hFFFF, 16'h7FFF);
    offer_item(KIND_WRITE, 16'hFFFF, 16'h8000);
    offer_item(KIND_RESTART, $urandom, $urandom);
    offer_item(KIND_FRAME, $urandom, $urandom);
    drain_player();
    // half speed looping over two frames: opposite extremes cancel to zero
    program_player(18'h08000, 1'b1, 18'd2, 1'b1);
    offer_item(KIND_RESTART, $urandom, $urandom);
    repeat (5) offer_item(KIND_FRAME, $urandom, $urandom);
    drain_player();
    // top speed, mono, three frames looping
    program_player(18'h3FFFF, 1'b1, 18'd3, 1'b0);
    offer_item(KIND_RESTART, $urandom, $urandom);
    repeat (3) offer_item(KIND_FRAME, $urandom, $urandom);
    drain_player();
    // standing still, no loop; phase left over may sit past the end
    program_player(18'd0, 1'b0, 18'd2, 1'b0);
    repeat (2) offer_item(KIND_FRAME, $urandom, $urandom);
    offer_item(KIND_RESTART, $urandom, $urandom);
    offer_item(KIND_FRAME, $urandom, $urandom);
  endtask

  task automatic run_phase(input int unsigned idx);
    logic [17:0] spd, lenw;
    logic        lp, st;
    logic [1:0]  kind;
    logic [15:0] addr, value;
    int unsigned len_eff, chans, since_restart, r;
    bit          bounded;
    case (idx)
      0: begin spd = 18'd0;      lp = 1'b1; lenw = 18'd65536;  st = 1'b1; end
      1: begin spd = 18'd131072; lp = 1'b0; lenw = 18'd0;      st = 1'b0; end
      2: begin spd = 18'h3FFFF;  lp = 1'b1; lenw = 18'd100;    st = 1'b1; end
      3: begin spd = $urandom;   lp = 1'b0; lenw = 18'd131071; st = 1'b0; end
      4: begin spd = 18'd1;      lp = 1'b1; lenw = 18'd128;    st = 1'b1; end
      default: begin
        case ($urandom_range(3))
          0:       spd = $urandom;
          1:       spd = $urandom_range(131072);
          2:       spd = 18'd65536 + $urandom_range(255) - 128;
          default: spd = $urandom_range(4096);
        endcase
        r = $urandom_range(5);
        if (r < 3) lenw = $urandom_range(16, 1);
        else if (r < 5) lenw = $urandom_range(128, 17);
        else lenw = $urandom_range(65536, 129);
        if ($urandom_range(3) == 0) lenw[17] = 1'b1;
        lp = $urandom;
        st = $urandom;
      end
    endcase
    drain_player();
    program_player(spd, lp, lenw, st);
    calm = (idx != CHOKE_PHASE) && ($urandom_range(3) == 0);

    len_eff = (lenw[16:0] == 0) ? 1 : (lenw[16:0] > 65536) ? 65536 : lenw[16:0];
    chans = st ? 2 : 1;
    // Long clips: only the written prefix may be read, so keep the phase
    // near the start by restarting often enough.
    bounded = (len_eff * chans > CLIP_PREFIX);
    since_restart = 0;
    if (bounded) offer_item(KIND_RESTART, $urandom, $urandom);
    if (idx == CHOKE_PHASE) choke_req = 1'b1;

    repeat (PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (bounded && since_restart >= MAX_REQS) kind = KIND_RESTART;
      else if (r < 62) kind = KIND_FRAME;
      else if (r < 80) kind = KIND_WRITE;
      else if (r < 94) kind = KIND_RESTART;
      else kind = KIND_UNUSED;
      addr  = $urandom;
      value = $urandom;
      if (kind == KIND_WRITE) begin
        if ($urandom_range(4) != 0) addr = $urandom_range(CLIP_PREFIX - 1);
        case ($urandom_range(7))
          0:       value = 16'h8000;
          1:       value = 16'h7FFF;
          default: ;
        endcase
      end
      if (kind == KIND_FRAME) since_restart++;
      if (kind == KIND_RESTART) since_restart = 0;
      offer_item(kind, addr, value);
    end
    calm = 1'b0;
  endtask

  // Result side: random ready pattern, one long hold-off when asked.
  initial begin
    int unsigned hold;
    forever begin
      if (choke_req && !choke_done) begin
        m_axis_tready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk_i);
        choke_done = 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
        repeat (1 + 4 * pick_gap(calm)) @(posedge clk_i);
        hold = pick_gap(calm);
        if (hold != 0) begin
          m_axis_tready <= 1'b0;
          repeat (hold) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("variable_speed_sample_player verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_clip();
    directed_checks();
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) run_phase(p);
    drain_player();
    if (mismatches == 0) begin
      $display("variable_speed_sample_player verification clean");
    end else begin
      $display("variable_speed_sample_player verification failed");
    end
    $finish;
  end

endmodule
